>>> design/cdss_pkg.sv
// Shared constants, types and the segment font of the countdown display scanner.
package cdss_pkg;

   localparam int unsigned SecondsWidth      = 14;
   localparam int unsigned ThresholdWidth    = 10;
   localparam int unsigned AccWidth          = 10;
   localparam int unsigned SegmentWidth      = 7;
   localparam int unsigned PositionWidth     = 2;
   localparam int unsigned DigitCountDefault = 4;
   localparam int unsigned DivShift          = 28;
   localparam int unsigned SecondsMax        = (1 << SecondsWidth) - 1;

   localparam logic [ThresholdWidth-1:0] ThresholdReset = ThresholdWidth'(400);
   localparam logic [AccWidth:0]         MsPerStep      = (AccWidth + 1)'(2);
   localparam logic [AccWidth:0]         AccMax         = (AccWidth + 1)'((1 << AccWidth) - 1);

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   typedef struct packed {
      logic [PositionWidth-1:0] digit_position;
      logic [SegmentWidth-1:0]  segments;
      logic [SecondsWidth-1:0]  remaining_seconds;
      logic                     blink;
   } result_type;

   // Segment pattern of one decimal digit, bit0 = a through bit6 = g.
   function automatic logic [SegmentWidth-1:0] seg_font(input logic [3:0] digit);
      logic [SegmentWidth-1:0] pattern;
      unique case (digit)
         4'd0:    pattern = 7'h3F;
         4'd1:    pattern = 7'h06;
         4'd2:    pattern = 7'h5B;
         4'd3:    pattern = 7'h4F;
         4'd4:    pattern = 7'h66;
         4'd5:    pattern = 7'h6D;
         4'd6:    pattern = 7'h7D;
         4'd7:    pattern = 7'h07;
         4'd8:    pattern = 7'h7F;
         4'd9:    pattern = 7'h6F;
         default: pattern = '0;
      endcase
      return pattern;
   endfunction

endpackage

>>> design/cdss_digits.sv
// Binary seconds to per-digit seven-segment patterns, one reciprocal multiply per digit.
module cdss_digits import cdss_pkg::*; #(
   parameter int unsigned DIGIT_COUNT = DigitCountDefault
) (
   input  logic [SecondsWidth-1:0] value,
   output logic [SegmentWidth-1:0] patterns [DIGIT_COUNT]
);

   // quotients[k] = value / 10**k
   logic [SecondsWidth-1:0] quotients [DIGIT_COUNT+1];

   for (genvar k = 0; k <= DIGIT_COUNT; k++) begin : g_quot
      localparam longint unsigned Pow = 64'd10 ** k;
      if (Pow == 64'd1) begin : g_unit
         assign quotients[k] = value;
      end else if (Pow > 64'(SecondsMax)) begin : g_zero
         assign quotients[k] = '0;
      end else begin : g_div
         localparam longint unsigned Recip = (64'd1 << DivShift) / Pow + 64'd1;
         localparam logic [DivShift-1:0] RecipBits = DivShift'(Recip);
         logic [SecondsWidth+DivShift-1:0] product;
         assign product = {{DivShift{1'b0}}, value} * {{SecondsWidth{1'b0}}, RecipBits};
         assign quotients[k] = product[SecondsWidth+DivShift-1:DivShift];
      end
   end

   for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_digit
      logic [SecondsWidth-1:0] tens;
      logic [SecondsWidth-1:0] rem;
      // times ten as 8x + 2x; wraparound is harmless, the remainder is below ten
      assign tens = {quotients[k+1][SecondsWidth-4:0], 3'b000}
                  + {quotients[k+1][SecondsWidth-2:0], 1'b0};
      assign rem  = quotients[k] - tens;
      assign patterns[k] = seg_font(rem[3:0]);
   end

endmodule

>>> design/countdown_seven_segment_scanner.sv
// Top level of the countdown timer and multiplexed seven-segment scanner.
//
// Usage:
//   req channel (valid/ready) carries one transaction per item: a load
//   (operation = 1) sets the remaining seconds, a tick (operation = 0)
//   stands for one millisecond. Every second tick is a scan step and
//   produces exactly one rsp transaction: the digit position driven, its
//   segment pattern, the remaining seconds and the blink flag. Loads and
//   the first tick of each pair produce nothing.
//   csr_write_enable writes csr_write_data into the second threshold in
//   the same cycle; write it only while the block is idle.
// Timing:
//   A transaction lands in the input register at the accepting edge; its
//   result is pushed into the result queue when the input stage advances.
//   One transaction is taken per cycle unless a full result queue stalls
//   the input stage; the only loop is the timer state update.
// Reset and stalls:
//   Synchronous reset clears the counters, blanks all digits and restores a
//   threshold of 400. A two-entry result queue (output register plus skid)
//   absorbs rsp_ready stalls; req_ready drops only when the queue is full
//   and the waiting transaction would add another result.
module countdown_seven_segment_scanner import cdss_pkg::*; #(
   parameter int unsigned DIGIT_COUNT = DigitCountDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic [SecondsWidth-1:0]   req_load_seconds,
   input  logic                      req_run,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PositionWidth-1:0]  rsp_digit_position,
   output logic [SegmentWidth-1:0]   rsp_segments,
   output logic [SecondsWidth-1:0]   rsp_remaining_seconds,
   output logic                      rsp_blink,
   input  logic                      csr_write_enable,
   input  logic [ThresholdWidth-1:0] csr_write_data
);

   localparam int unsigned PosWidth = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [PosWidth-1:0] LastPos = PosWidth'(DIGIT_COUNT - 1);

   // configuration
   logic [ThresholdWidth-1:0] threshold_ff;

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic                    in_operation_ff;
   logic [SecondsWidth-1:0] in_load_ff;
   logic                    in_run_ff;

   // timer and scan state
   logic                    tick_phase_ff, tick_phase_in;
   logic [AccWidth-1:0]     acc_ff, acc_in;
   logic [SecondsWidth-1:0] seconds_ff, seconds_in;
   logic [SegmentWidth-1:0] patterns_ff [DIGIT_COUNT];
   logic [PosWidth-1:0]     scan_pos_ff, scan_pos_in;
   logic                    blink_ff, blink_in;

   // result queue
   logic       head_valid_ff, head_valid_in;
   result_type head_ff, head_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic                    accept;
   logic                    scan_step;
   logic                    advance;
   logic                    push;
   logic                    pop;
   logic [AccWidth:0]       acc_sum;
   logic [AccWidth-1:0]     acc_sat;
   logic                    count_second;
   logic [SecondsWidth-1:0] seconds_dec;
   logic [SegmentWidth-1:0] new_patterns [DIGIT_COUNT];
   logic [PosWidth+1:0]     pos_ext;
   result_type              result;

   // Handshake: the input stage drains unless it holds a scan step and the
   // result queue is full.
   assign scan_step = in_valid_ff && (in_operation_ff == OP_TICK) && tick_phase_ff;
   assign advance   = in_valid_ff && (!scan_step || !skid_valid_ff);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign push      = advance && scan_step;
   assign pop       = head_valid_ff && rsp_ready;

   // Millisecond accumulator, saturating at its full scale.
   assign acc_sum      = {1'b0, acc_ff} + MsPerStep;
   assign acc_sat      = (acc_sum > AccMax) ? AccMax[AccWidth-1:0] : acc_sum[AccWidth-1:0];
   assign count_second = in_run_ff && (acc_sat > threshold_ff);
   assign seconds_dec  = (seconds_ff != '0) ? seconds_ff - SecondsWidth'(1) : '0;

   cdss_digits #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_digits (
      .value    (seconds_dec),
      .patterns (new_patterns)
   );

   // Result of the current scan step; a counted second shows its new
   // patterns immediately.
   assign pos_ext = {2'b00, scan_pos_ff};

   always_comb begin
      result.digit_position    = pos_ext[PositionWidth-1:0];
      result.segments          = count_second ? new_patterns[scan_pos_ff]
                                              : patterns_ff[scan_pos_ff];
      result.remaining_seconds = count_second ? seconds_dec : seconds_ff;
      result.blink             = blink_ff ^ count_second;
   end

   // Next state of the timer.
   always_comb begin
      tick_phase_in = tick_phase_ff;
      acc_in        = acc_ff;
      seconds_in    = seconds_ff;
      scan_pos_in   = scan_pos_ff;
      blink_in      = blink_ff;
      if (advance) begin
         if (in_operation_ff == OP_LOAD) begin
            seconds_in = in_load_ff;
         end else if (!tick_phase_ff) begin
            tick_phase_in = 1'b1;
         end else begin
            tick_phase_in = 1'b0;
            acc_in        = count_second ? '0 : acc_sat;
            seconds_in    = count_second ? seconds_dec : seconds_ff;
            blink_in      = blink_ff ^ count_second;
            scan_pos_in   = (scan_pos_ff == LastPos) ? '0 : scan_pos_ff + PosWidth'(1);
         end
      end
   end

   // Input register occupancy.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
      end
   end

   // Two-entry result queue: pop shifts skid into head, push fills the
   // first free slot.
   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         head_valid_in = skid_valid_ff;
         head_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!head_valid_in) begin
            head_valid_in = 1'b1;
            head_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= ThresholdReset;
         in_valid_ff   <= 1'b0;
         tick_phase_ff <= 1'b0;
         acc_ff        <= '0;
         seconds_ff    <= '0;
         scan_pos_ff   <= '0;
         blink_ff      <= 1'b0;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            threshold_ff <= csr_write_data;
         end
         in_valid_ff   <= in_valid_in;
         tick_phase_ff <= tick_phase_in;
         acc_ff        <= acc_in;
         seconds_ff    <= seconds_in;
         scan_pos_ff   <= scan_pos_in;
         blink_ff      <= blink_in;
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Digit patterns: blank at reset, rebuilt at each counted second.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            patterns_ff[k] <= '0;
         end
      end else if (push && count_second) begin
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            patterns_ff[k] <= new_patterns[k];
         end
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_operation_ff <= req_operation;
         in_load_ff      <= req_load_seconds;
         in_run_ff       <= req_run;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid             = head_valid_ff;
   assign rsp_digit_position    = head_ff.digit_position;
   assign rsp_segments          = head_ff.segments;
   assign rsp_remaining_seconds = head_ff.remaining_seconds;
   assign rsp_blink             = head_ff.blink;

endmodule

>>> verif/countdown_seven_segment_scanner_tb.sv
// Self-checking testbench for the countdown timer and seven-segment scanner.
`timescale 1ns / 1ps

module countdown_seven_segment_scanner_tb import cdss_pkg::*; ();

   // Timer constants, kept apart from the design's own package values.
   localparam int unsigned MS_PER_SCAN  = 2;
   localparam int unsigned ACC_CEILING  = 1023;
   localparam int unsigned DIGITS       = 4;
   // Cycles with no transaction on either channel before the run is declared hung.
   localparam int unsigned QUIET_LIMIT  = 2000;
   // Length of the one long receiver hold-off.
   localparam int unsigned HOLD_CYCLES  = 300;
   // Cycles to let the pipeline settle once the last expected scan has arrived.
   localparam int unsigned SETTLE       = 4;
   // Ten glyphs, 7 bits each, digit 0 in the low bits.
   localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                     7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

   typedef enum logic [1:0] {
      ROW_TICK,
      ROW_LOAD,
      ROW_THRESHOLD
   } row_kind_type;

   // One line of the opening sequence. value is the load (or the ignored
   // load field of a tick) or the threshold to program.
   typedef struct packed {
      row_kind_type kind;
      logic [13:0]  value;
      logic         run;
      logic         pinned;
      result_type   want;
   } plan_row_type;

   localparam result_type NO_SCAN = '0;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_operation = 1'b0;
   logic [SecondsWidth-1:0]   req_load_seconds = '0;
   logic                      req_run = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PositionWidth-1:0]  rsp_digit_position;
   logic [SegmentWidth-1:0]   rsp_segments;
   logic [SecondsWidth-1:0]   rsp_remaining_seconds;
   logic                      rsp_blink;
   logic                      csr_write_enable = 1'b0;
   logic [ThresholdWidth-1:0] csr_write_data = '0;

   // Shadow copy of the timer state.
   bit                        tick_half;
   int unsigned               acc_ms;
   logic [SecondsWidth-1:0]   secs_left;
   logic [SegmentWidth-1:0]   shown [DIGITS];
   int unsigned               scan_pos;
   bit                        blink_now;
   int unsigned               threshold_ms = 400;

   result_type                awaited_scans [$];
   int unsigned               mismatch_count = 0;
   int unsigned               quiet_cycles = 0;
   bit                        gaps_enabled = 1'b1;
   bit                        hold_off_rsp = 1'b0;

   // Opening sequence. Pinned rows carry a scan that can be read straight off
   // the behavior; the rest are checked against the shadow model.
   plan_row_type opening_plan [25] = '{
      // Out of reset: first tick of a pair is silent, second shows blank digit 0.
      '{ROW_TICK,      14'd0,     1'b0, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b0, 1'b1, '{2'd0, 7'h00, 14'd0, 1'b0}},
      // Load the largest count; digits stay blank until a second is counted.
      '{ROW_LOAD,      14'h3FFF,  1'b0, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'h3FFF,  1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b1, '{2'd1, 7'h00, 14'd16383, 1'b0}},
      // Drop the threshold to 2.
      '{ROW_THRESHOLD, 14'd2,     1'b0, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b0, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b0, 1'b1, '{2'd2, 7'h00, 14'd16383, 1'b0}},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b1, '{2'd3, 7'h7D, 14'd16382, 1'b1}},
      // Countdown at zero: time holds, digits rebuild to all zeros, blink toggles.
      '{ROW_LOAD,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b1, '{2'd1, 7'h3F, 14'd0, 1'b0}},
      '{ROW_LOAD,      14'd9876,  1'b0, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      // Threshold of zero: every running scan counts a second.
      '{ROW_THRESHOLD, 14'd0,     1'b0, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b1, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b0, 1'b0, NO_SCAN},
      '{ROW_TICK,      14'd0,     1'b0, 1'b0, NO_SCAN}
   };

   // Random phases: threshold, transaction count, share of loads in percent.
   // Phase 0 is tick heavy so the accumulator climbs into saturation under a
   // threshold it can never exceed; phase 1 then counts at once. The last
   // threshold is drawn at run time.
   int unsigned phase_threshold [4] = '{1023, 1000, 2, 0};
   int unsigned phase_items     [4] = '{1100, 100, 150, 100};
   int unsigned phase_load_pct  [4] = '{2, 15, 15, 15};

   countdown_seven_segment_scanner dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_load_seconds      (req_load_seconds),
      .req_run               (req_run),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_digit_position    (rsp_digit_position),
      .rsp_segments          (rsp_segments),
      .rsp_remaining_seconds (rsp_remaining_seconds),
      .rsp_blink             (rsp_blink),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   always #1 clock = ~clock;

   task automatic report(input string msg);
      mismatch_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Advance the shadow timer by one transaction and return the scan it shows.
   task automatic step_countdown(input op_type op, input logic [13:0] load,
                                 input logic run, output bit scanned,
                                 output result_type scan);
      int unsigned v;
      int          k;
      scanned = 1'b0;
      scan    = NO_SCAN;
      if (op == OP_LOAD) begin
         // Load only replaces the time; the digits catch up at the next second.
         secs_left = load;
      end else if (!tick_half) begin
         tick_half = 1'b1;
      end else begin
         tick_half = 1'b0;
         acc_ms = (acc_ms + MS_PER_SCAN > ACC_CEILING) ? ACC_CEILING : acc_ms + MS_PER_SCAN;
         if (run && acc_ms > threshold_ms) begin
            acc_ms = 0;
            if (secs_left != 0) begin
               secs_left = secs_left - 1'b1;
            end
            v = secs_left;
            for (k = 0; k < DIGITS; k++) begin
               shown[k] = GLYPHS[(v % 10) * 7 +: 7];
               v = v / 10;
            end
            blink_now = ~blink_now;
         end
         scanned                = 1'b1;
         scan.digit_position    = scan_pos[1:0];
         scan.segments          = shown[scan_pos];
         scan.remaining_seconds = secs_left;
         scan.blink             = blink_now;
         scan_pos               = (scan_pos + 1) % DIGITS;
      end
   endtask

   // Offer one transaction after a random gap and record what it should show.
   task automatic send_item(input op_type op, input logic [13:0] load, input logic run,
                            input bit pinned, input result_type want);
      int unsigned gap;
      bit          scanned;
      result_type  scan;
      gap = gaps_enabled ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_load_seconds <= load;
      req_run          <= run;
      do @(posedge clock); while (!(req_valid && req_ready));
      step_countdown(op, load, run, scanned, scan);
      if (pinned) begin
         awaited_scans.push_back(want);
      end else if (scanned) begin
         awaited_scans.push_back(scan);
      end
   endtask

   // Drop valid and hold until every awaited scan has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_scans.size() != 0) @(posedge clock);
   endtask

   // Program the threshold with the block idle; silent transactions may still
   // be in flight, so let the pipeline settle first.
   task automatic write_threshold(input logic [ThresholdWidth-1:0] value);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      threshold_ms = value;
   endtask

   // Mostly full-range counts, with a share of small ones so that the
   // countdown reaches zero, and the largest count now and then.
   function automatic logic [13:0] pick_seconds();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick < 2) begin
         return 14'($urandom_range(0, 20));
      end else if (pick == 2) begin
         return 14'h3FFF;
      end
      return 14'($urandom_range(0, 16383));
   endfunction

   // Response side: random back-pressure per scan, plus one long hold-off
   // when the stimulus asks for it, counted here.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_rsp = 1'b0;
         end
         stall = gaps_enabled ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare every accepted scan, field by field, with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_scans.size() == 0) begin
            report($sformatf("unexpected scan: position %0d segments %02h seconds %0d",
                             rsp_digit_position, rsp_segments, rsp_remaining_seconds));
         end else begin
            want = awaited_scans.pop_front();
            if (rsp_digit_position !== want.digit_position) begin
               report($sformatf("digit_position got %0d, expected %0d",
                                rsp_digit_position, want.digit_position));
            end
            if (rsp_segments !== want.segments) begin
               report($sformatf("segments got %02h, expected %02h",
                                rsp_segments, want.segments));
            end
            if (rsp_remaining_seconds !== want.remaining_seconds) begin
               report($sformatf("remaining_seconds got %0d, expected %0d",
                                rsp_remaining_seconds, want.remaining_seconds));
            end
            if (rsp_blink !== want.blink) begin
               report($sformatf("blink got %0d, expected %0d", rsp_blink, want.blink));
            end
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("countdown_seven_segment_scanner: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          r;
      int unsigned p;
      int unsigned i;
      op_type      op;
      // Reset state of the shadow timer.
      tick_half = 1'b0;
      acc_ms    = 0;
      secs_left = '0;
      scan_pos  = 0;
      blink_now = 1'b0;
      foreach (shown[k]) shown[k] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the opening sequence.
      for (r = 0; r < $size(opening_plan); r++) begin
         case (opening_plan[r].kind)
            ROW_THRESHOLD: begin
               write_threshold(opening_plan[r].value[ThresholdWidth-1:0]);
            end
            ROW_LOAD: begin
               send_item(OP_LOAD, opening_plan[r].value, opening_plan[r].run,
                         opening_plan[r].pinned, opening_plan[r].want);
            end
            default: begin
               send_item(OP_TICK, opening_plan[r].value, opening_plan[r].run,
                         opening_plan[r].pinned, opening_plan[r].want);
            end
         endcase
      end

      // Random phases, one threshold each.
      for (p = 0; p < 4; p++) begin
         write_threshold((p == 3) ? ThresholdWidth'($urandom_range(3, 60))
                                  : ThresholdWidth'(phase_threshold[p]));
         // Hold off the receiver while the sender keeps going, so the
         // result queue fills and the input stalls.
         if (p == 2) begin
            hold_off_rsp = 1'b1;
         end
         for (i = 0; i < phase_items[p]; i++) begin
            // Switch between gapped and back-to-back stretches now and then.
            if ($urandom_range(0, 39) == 0) begin
               gaps_enabled = !gaps_enabled;
            end
            // Pause the sender halfway until every scan is back.
            if (i == phase_items[p] / 2) begin
               drain();
            end
            op = ($urandom_range(0, 99) < phase_load_pct[p]) ? OP_LOAD : OP_TICK;
            send_item(op, pick_seconds(), $urandom_range(0, 9) != 0, 1'b0, NO_SCAN);
         end
      end

      // drain returns only once nothing is awaited; otherwise the watchdog fires.
      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("countdown_seven_segment_scanner: match");
      end else begin
         $display("countdown_seven_segment_scanner: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/cdss_pkg.sv
design/cdss_digits.sv
design/countdown_seven_segment_scanner.sv
verif/countdown_seven_segment_scanner_tb.sv
